### hdl/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru package
// shared types and constants of the lru frame replacement unit
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAME_W = 6;
    localparam int NUM_FRAMES_DEF = 64;

    typedef enum logic [1:0] {
        ST_REF_DONE = 2'd0,
        ST_EVICTED  = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic {
        MODE_REF   = 1'b0,
        MODE_EVICT = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                 mode;
        logic [FRAME_W-1:0]   frame_index;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0]   victim_frame;
        logic [1:0]           status;
    } t_out_item;

    // one link memory write
    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] addr;
        logic [FRAME_W-1:0] data;
    } t_link_wr;

endpackage

### hdl/lru_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru link memory
// one link array, one read port and two write ports, registered read
// ----------------------------------------------------------------------------
module lru_link_mem #(
    parameter int NUM_FRAMES = lru_pkg::NUM_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic [lru_pkg::FRAME_W-1:0] i_rd_addr,
    output logic [lru_pkg::FRAME_W-1:0] o_rd_data,
    input  lru_pkg::t_link_wr           i_wr_a,
    input  lru_pkg::t_link_wr           i_wr_b
);
    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    logic [lru_pkg::FRAME_W-1:0] r_mem [NUM_FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_wr_a.en) begin
            r_mem[i_wr_a.addr[AW-1:0]] <= i_wr_a.data;
        end
        if (i_wr_b.en) begin
            r_mem[i_wr_b.addr[AW-1:0]] <= i_wr_b.data;
        end
        o_rd_data <= r_mem[i_rd_addr[AW-1:0]];
    end
endmodule

### hdl/lru_frame_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru frame replacement unit
// exact least-recently-used order over physical frames as a linked list
// ----------------------------------------------------------------------------
// usage: an item is taken on a clock edge with i_start high and o_busy low.
// mode 0 references a frame: a tracked frame moves to the newest end, an
// untracked one is appended there. mode 1 evicts the oldest frame and
// returns it, or status 2 when the order is empty.
// after the accepting edge come a read cycle for the registered read of both
// link memories at the frame (or the oldest frame) and an update cycle that
// writes the links back and registers the result. the result is on o_out
// with o_done high in the cycle after the update cycle. o_busy is high
// through the read and update cycles only, so a new item can be taken in the
// same cycle as o_done, but not before the unit is through with the last one.
// indexes at or above NUM_FRAMES are ignored and reported as done.
// reset clears the tracked bits and empties the order; link memories are not
// cleared since a link is only read for a tracked frame.
// the receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module lru_frame_replacement_unit #(
    parameter int NUM_FRAMES = lru_pkg::NUM_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lru_pkg::t_in_item  i_in,
    output logic               o_busy,
    output logic               o_done,
    output lru_pkg::t_out_item o_out
);
    localparam int FW = lru_pkg::FRAME_W;
    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [FW:0] NF = (FW+1)'(NUM_FRAMES);

    lru_pkg::t_state r_state, n_state;
    lru_pkg::t_in_item r_item;
    logic [NUM_FRAMES-1:0] r_tracked, n_tracked;
    logic [FW-1:0] r_oldest, n_oldest, r_newest, n_newest;
    logic r_empty, n_empty;
    logic [FW-1:0] w_rd_addr, w_older, w_newer;
    lru_pkg::t_link_wr w_old_a, w_old_b, w_new_a, w_new_b;
    lru_pkg::t_out_item w_out;
    logic w_accept, w_in_range, w_is_tr;
    logic [FW-1:0] w_f;

    assign w_accept = i_start && (r_state == lru_pkg::S_IDLE);
    assign w_f = r_item.frame_index;
    assign w_in_range = {1'b0, w_f} < NF;
    assign w_is_tr = w_in_range && r_tracked[w_f[AW-1:0]];

    // read address: the frame for a reference, the oldest for an evict
    always_comb begin
        w_rd_addr = (r_item.mode == lru_pkg::MODE_EVICT) ? r_oldest : w_f;
    end

    lru_link_mem #(.NUM_FRAMES(NUM_FRAMES)) u_older (
        .i_clk(i_clk), .i_rd_addr(w_rd_addr), .o_rd_data(w_older),
        .i_wr_a(w_old_a), .i_wr_b(w_old_b)
    );
    lru_link_mem #(.NUM_FRAMES(NUM_FRAMES)) u_newer (
        .i_clk(i_clk), .i_rd_addr(w_rd_addr), .o_rd_data(w_newer),
        .i_wr_a(w_new_a), .i_wr_b(w_new_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lru_pkg::S_IDLE:   if (i_start) n_state = lru_pkg::S_READ;
            lru_pkg::S_READ:   n_state = lru_pkg::S_UPDATE;
            lru_pkg::S_UPDATE: n_state = lru_pkg::S_IDLE;
            default:           n_state = lru_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_tracked = r_tracked;
        n_oldest  = r_oldest;
        n_newest  = r_newest;
        n_empty   = r_empty;
        w_old_a = '0;
        w_old_b = '0;
        w_new_a = '0;
        w_new_b = '0;
        w_out = '{victim_frame: '0, status: lru_pkg::ST_REF_DONE};
        if (r_state == lru_pkg::S_UPDATE) begin
            if (r_item.mode == lru_pkg::MODE_EVICT) begin
                if (r_empty) begin
                    w_out.status = lru_pkg::ST_EMPTY;
                end else begin
                    w_out.status = lru_pkg::ST_EVICTED;
                    w_out.victim_frame = r_oldest;
                    n_tracked[r_oldest[AW-1:0]] = 1'b0;
                    if (r_oldest == r_newest) n_empty = 1'b1;
                    else n_oldest = w_newer;
                end
            end else if (w_in_range && !(w_is_tr && w_f == r_newest)) begin
                n_tracked[w_f[AW-1:0]] = 1'b1;
                // unlink a tracked frame
                if (w_is_tr) begin
                    if (w_f == r_oldest) begin
                        n_oldest = w_newer;
                    end else begin
                        w_new_a = '{en: 1'b1, addr: w_older, data: w_newer};
                        w_old_a = '{en: 1'b1, addr: w_newer, data: w_older};
                    end
                end
                // append at the newest end
                if (r_empty && !w_is_tr) begin
                    n_oldest = w_f;
                    n_empty  = 1'b0;
                end else begin
                    w_old_b = '{en: 1'b1, addr: w_f, data: r_newest};
                    w_new_b = '{en: 1'b1, addr: r_newest, data: w_f};
                end
                n_newest = w_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lru_pkg::S_IDLE;
            r_tracked <= '0;
            r_oldest  <= '0;
            r_newest  <= '0;
            r_empty   <= 1'b1;
            o_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tracked <= n_tracked;
            r_oldest  <= n_oldest;
            r_newest  <= n_newest;
            r_empty   <= n_empty;
            o_done    <= (r_state == lru_pkg::S_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in;
        if (r_state == lru_pkg::S_UPDATE) o_out <= w_out;
    end

    assign o_busy = (r_state != lru_pkg::S_IDLE);

    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::S_UPDATE) |=> o_done)
        else $error("done missing after update");
    a_empty_no_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_tracked == '0))
        else $error("empty order with tracked frames");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("not busy after transfer");
endmodule

### test/tb_lru_frame_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru frame replacement unit testbench
// drives reference and evict commands and compares every result with an
// exact lru order kept as a linked list in the bench; directed rows first,
// then random phases with sender gaps and one drain pause
// ----------------------------------------------------------------------------
module tb_lru_frame_replacement_unit;

    localparam int NF = lru_pkg::NUM_FRAMES_DEF;
    localparam int WATCHDOG = 2000;
    localparam int FW = lru_pkg::FRAME_W;
    localparam int IN_W = $bits(lru_pkg::t_in_item);

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    lru_pkg::t_in_item  i_in = '0;
    logic               o_busy;
    logic               o_done;
    lru_pkg::t_out_item o_out;

    lru_frame_replacement_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_in   (i_in),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_out  (o_out)
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the recency order
    logic [FW-1:0] lnk_older [NF];
    logic [FW-1:0] lnk_newer [NF];
    logic          in_order  [NF];
    logic [FW-1:0] lru_head, mru_tail;
    logic          order_is_empty;

    lru_pkg::t_out_item pending_results [$];
    int errors = 0;
    int idle_cycles = 0;
    int n_evicted = 0, n_empty = 0, n_refs = 0;

    typedef struct {
        lru_pkg::t_mode     mode;
        logic [FW-1:0]      frame;
        logic               fixed;
        lru_pkg::t_out_item want;
    } t_row;

    function automatic void append_newest(logic [FW-1:0] f);
        if (order_is_empty) begin
            lru_head = f;
            order_is_empty = 1'b0;
        end else begin
            lnk_older[f] = mru_tail;
            lnk_newer[mru_tail] = f;
        end
        mru_tail = f;
    endfunction

    function automatic lru_pkg::t_out_item predict_lru(lru_pkg::t_mode m,
                                                       logic [FW-1:0] f);
        lru_pkg::t_out_item r;
        r.victim_frame = '0;
        r.status = lru_pkg::ST_REF_DONE;
        if (m == lru_pkg::MODE_REF) begin
            if (!in_order[f]) begin
                append_newest(f);
                in_order[f] = 1'b1;
            end else if (f != mru_tail) begin
                if (f == lru_head) begin
                    lru_head = lnk_newer[f];
                end else begin
                    lnk_newer[lnk_older[f]] = lnk_newer[f];
                    lnk_older[lnk_newer[f]] = lnk_older[f];
                end
                append_newest(f);
            end
        end else if (order_is_empty) begin
            r.status = lru_pkg::ST_EMPTY;
        end else begin
            r.victim_frame = lru_head;
            r.status = lru_pkg::ST_EVICTED;
            in_order[lru_head] = 1'b0;
            if (lru_head == mru_tail) order_is_empty = 1'b1;
            else lru_head = lnk_newer[lru_head];
        end
        return r;
    endfunction

    // one transfer; gap_pct is the chance, drawn anew each time, of idling once more first
    task automatic send_cmd(lru_pkg::t_mode m, logic [FW-1:0] f, int gap_pct,
                            logic fixed, lru_pkg::t_out_item want);
        lru_pkg::t_out_item p;
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            i_in <= lru_pkg::t_in_item'(IN_W'($urandom));
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in.mode <= m;
        i_in.frame_index <= f;
        do @(posedge i_clk); while (o_busy);
        p = predict_lru(m, f);
        if (fixed && p != want) begin
            $display("%0t table row disagrees with predictor: exp %p got %p",
                     $time, want, p);
            errors++;
        end
        pending_results.push_back(p);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            lru_pkg::t_out_item e;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_out);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_out.victim_frame !== e.victim_frame)
                    $display("%0t victim_frame exp %0d got %0d", $time,
                             e.victim_frame, o_out.victim_frame);
                if (o_out.status !== e.status)
                    $display("%0t status exp %0d got %0d", $time, e.status,
                             o_out.status);
                if (o_out !== e) errors++;
                case (e.status)
                    lru_pkg::ST_EVICTED: n_evicted++;
                    lru_pkg::ST_EMPTY:   n_empty++;
                    default:             n_refs++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    t_row rows [$];

    function automatic t_row mk(lru_pkg::t_mode m, int f, logic fx, int v,
                                lru_pkg::t_status s);
        t_row r;
        r.mode = m;
        r.frame = f[FW-1:0];
        r.fixed = fx;
        r.want.victim_frame = v[FW-1:0];
        r.want.status = s;
        return r;
    endfunction

    initial begin
        int pool;
        int gap;
        for (int i = 0; i < NF; i++) in_order[i] = 1'b0;
        lru_head = '0;
        mru_tail = '0;
        order_is_empty = 1'b1;

        rows.push_back(mk(lru_pkg::MODE_EVICT, 63, 1'b1, 0, lru_pkg::ST_EMPTY));
        rows.push_back(mk(lru_pkg::MODE_REF,    0, 1'b1, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  0, 1'b1, 0, lru_pkg::ST_EVICTED));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  5, 1'b1, 0, lru_pkg::ST_EMPTY));
        rows.push_back(mk(lru_pkg::MODE_REF,   63, 1'b1, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   63, 1'b1, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,    0, 1'b1, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   42, 1'b0, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   21, 1'b0, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   63, 1'b0, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   42, 1'b0, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_REF,   21, 1'b0, 0, lru_pkg::ST_REF_DONE));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  0, 1'b1, 0, lru_pkg::ST_EVICTED));
        rows.push_back(mk(lru_pkg::MODE_EVICT, 63, 1'b0, 0, lru_pkg::ST_EVICTED));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  0, 1'b0, 0, lru_pkg::ST_EVICTED));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  0, 1'b0, 0, lru_pkg::ST_EVICTED));
        rows.push_back(mk(lru_pkg::MODE_EVICT,  0, 1'b1, 0, lru_pkg::ST_EMPTY));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_cmd(rows[i].mode, rows[i].frame, 0, rows[i].fixed, rows[i].want);

        // four phases of gaps, small working sets mostly so the order fills
        for (int ph = 0; ph < 4; ph++) begin
            gap = (ph == 0) ? 0 : (ph == 2) ? 21 : 79;
            for (int k = 0; k < 150; k++) begin
                pool = ($urandom_range(3) == 0) ? NF : 8;
                send_cmd($urandom_range(99) < 30 ? lru_pkg::MODE_EVICT
                                                 : lru_pkg::MODE_REF,
                         FW'($urandom_range(pool - 1)), gap, 1'b0, '0);
                if (ph == 1 && k == 75) wait_drained();
            end
        end

        wait_drained();
        $display("covered %0d references, %0d evictions, %0d empty-order evicts",
                 n_refs, n_evicted, n_empty);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
